[rtl/core/uvc_pkg.sv]
// uvc_pkg: shared widths, request codes and controller/datapath bundles
// for the unused vertex compaction block; depends on nothing
package uvc_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int REQ_W        = 3;
  localparam int TRI_CORNERS  = 3;
  localparam int SEL_W        = 2;

  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd0;
  localparam logic [REQ_W-1:0] REQ_MARK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FIN   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMAP = 3'd3;
  localparam logic [REQ_W-1:0] REQ_QUERY = 3'd4;

  typedef struct packed {
    logic             latch_in;   // capture the accepted request
    logic             clr_step;   // write zero at sweep index, advance
    logic             mark_step;  // set used flag of selected corner
    logic             fin_step;   // one step of the rank walk
    logic             use_q;      // rank read address is the query vertex
    logic [SEL_W-1:0] sel;        // corner picked for write or read
    logic             rank_cap;   // capture rank data into remap slot
    logic [SEL_W-1:0] cap_slot;   // slot that the capture fills
    logic             q_cap;      // capture query read data
    logic             load_out;   // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic sweep_last;  // clearing sweep is at the last entry
    logic fin_done;    // rank walk finished, total is final
  } status_t;

endpackage

[rtl/core/uvc_ifs.sv]
// uvc_ifs: valid/ready channel interfaces for requests, results and config
// depends on uvc_pkg
interface uvc_in_if;
  import uvc_pkg::*;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [IDX_W-1:0] corner_a;
  logic [IDX_W-1:0] corner_b;
  logic [IDX_W-1:0] corner_c;
  logic [IDX_W-1:0] query_vertex;
  modport source (output valid, req_type, corner_a, corner_b, corner_c, query_vertex,
                  input ready);
  modport sink   (input valid, req_type, corner_a, corner_b, corner_c, query_vertex,
                  output ready);
endinterface

interface uvc_out_if;
  import uvc_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] new_a;
  logic [IDX_W-1:0] new_b;
  logic [IDX_W-1:0] new_c;
  logic             vertex_kept;
  logic [IDX_W-1:0] vertex_new_index;
  logic [CNT_W-1:0] kept_total;
  logic             range_error;
  modport source (output valid, new_a, new_b, new_c, vertex_kept, vertex_new_index,
                  kept_total, range_error, input ready);
  modport sink   (input valid, new_a, new_b, new_c, vertex_kept, vertex_new_index,
                  kept_total, range_error, output ready);
endinterface

interface uvc_cfg_if;
  import uvc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] vertex_count;
  modport source (output valid, vertex_count, input ready);
  modport sink   (input valid, vertex_count, output ready);
endinterface

[rtl/core/uvc_ram.sv]
// uvc_ram: generic one-write one-read ram with registered read data
// depends on nothing
module uvc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/uvc_dp.sv]
// uvc_dp: datapath with used bitmap and rank ram, request and result registers
// depends on uvc_pkg and uvc_ram
module uvc_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  uvc_pkg::cmd_t           cmd,
  output uvc_pkg::status_t        status,
  input  logic [uvc_pkg::REQ_W-1:0] in_req_type,
  input  logic [uvc_pkg::IDX_W-1:0] in_corner_a,
  input  logic [uvc_pkg::IDX_W-1:0] in_corner_b,
  input  logic [uvc_pkg::IDX_W-1:0] in_corner_c,
  input  logic [uvc_pkg::IDX_W-1:0] in_query_vertex,
  input  logic                    cfg_we,
  input  logic [uvc_pkg::CNT_W-1:0] cfg_vertex_count,
  output logic [uvc_pkg::IDX_W-1:0] out_new_a,
  output logic [uvc_pkg::IDX_W-1:0] out_new_b,
  output logic [uvc_pkg::IDX_W-1:0] out_new_c,
  output logic                    out_vertex_kept,
  output logic [uvc_pkg::IDX_W-1:0] out_vertex_new_index,
  output logic [uvc_pkg::CNT_W-1:0] out_kept_total,
  output logic                    out_range_error
);
  import uvc_pkg::*;

  logic [CNT_W-1:0] vc_r, n_eff;
  logic [REQ_W-1:0] req_r;
  logic [IDX_W-1:0] ca_r, cb_r, cc_r, q_r;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] run_r, run_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pidx_r;
  logic [IDX_W-1:0] res_a_r, res_b_r, res_c_r, res_new_r;
  logic             res_kept_r;

  logic [IDX_W-1:0] out_new_a_nxt, out_new_b_nxt, out_new_c_nxt, out_vertex_new_index_nxt;
  logic             out_vertex_kept_nxt, out_range_error_nxt;
  logic [CNT_W-1:0] out_kept_total_nxt;

  logic             bm_we, bm_wdata, bm_rdata;
  logic [IDX_W-1:0] bm_waddr, bm_raddr;
  logic             rk_we;
  logic [IDX_W-1:0] rk_waddr, rk_raddr, rk_wdata, rk_rdata;
  logic [IDX_W-1:0] sel_corner, cap_corner, cap_val;
  logic             sel_ok, cap_ok, q_ok, tri_err, kept_now;

  function automatic logic [IDX_W-1:0] pick(input logic [SEL_W-1:0] s,
                                            input logic [IDX_W-1:0] a,
                                            input logic [IDX_W-1:0] b,
                                            input logic [IDX_W-1:0] c);
    logic [IDX_W-1:0] v;
    unique case (s)
      2'd0:    v = a;
      2'd1:    v = b;
      default: v = c;
    endcase
    return v;
  endfunction

  // clamp to the table size
  assign n_eff = (vc_r > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vc_r;

  assign sel_corner = pick(cmd.sel, ca_r, cb_r, cc_r);
  assign cap_corner = pick(cmd.cap_slot, ca_r, cb_r, cc_r);
  assign sel_ok     = {1'b0, sel_corner} < n_eff;
  assign cap_ok     = {1'b0, cap_corner} < n_eff;
  assign q_ok       = {1'b0, q_r} < n_eff;
  assign tri_err    = ({1'b0, ca_r} >= n_eff) || ({1'b0, cb_r} >= n_eff) ||
                      ({1'b0, cc_r} >= n_eff);
  assign cap_val    = cap_ok ? rk_rdata : '0;
  assign kept_now   = q_ok && bm_rdata;

  // bitmap ports
  assign bm_we    = cmd.clr_step || (cmd.mark_step && sel_ok);
  assign bm_waddr = cmd.clr_step ? idx_r[IDX_W-1:0] : sel_corner;
  assign bm_wdata = !cmd.clr_step;
  assign bm_raddr = cmd.fin_step ? idx_r[IDX_W-1:0] : q_r;

  // rank ports
  assign rk_we    = cmd.fin_step && pend_r;
  assign rk_waddr = pidx_r;
  assign rk_wdata = run_r[IDX_W-1:0];
  assign rk_raddr = cmd.use_q ? q_r : sel_corner;

  assign status.sweep_last = (idx_r == CNT_W'(MAX_VERTICES - 1));
  assign status.fin_done   = (idx_r >= n_eff) && !pend_r;

  uvc_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  uvc_ram #(.WIDTH(IDX_W), .DEPTH(MAX_VERTICES)) u_rank (
    .clk   (clk),
    .we    (rk_we),
    .waddr (rk_waddr),
    .wdata (rk_wdata),
    .raddr (rk_raddr),
    .rdata (rk_rdata)
  );

  always_comb begin
    idx_nxt  = idx_r;
    run_nxt  = run_r;
    pend_nxt = pend_r;
    if (cmd.latch_in) begin
      idx_nxt  = '0;
      run_nxt  = '0;
      pend_nxt = 1'b0;
    end else if (cmd.clr_step) begin
      idx_nxt = idx_r + CNT_W'(1);
    end else if (cmd.fin_step) begin
      pend_nxt = idx_r < n_eff;
      if (idx_r < n_eff) begin
        idx_nxt = idx_r + CNT_W'(1);
      end
      if (pend_r && bm_rdata) begin
        run_nxt = run_r + CNT_W'(1);
      end
    end
  end

  // result fields, the ones that do not belong to the request stay zero
  always_comb begin
    out_new_a_nxt            = '0;
    out_new_b_nxt            = '0;
    out_new_c_nxt            = '0;
    out_vertex_kept_nxt      = 1'b0;
    out_vertex_new_index_nxt = '0;
    out_kept_total_nxt       = '0;
    out_range_error_nxt      = 1'b0;
    unique case (req_r)
      REQ_MARK: begin
        out_range_error_nxt = tri_err;
      end
      REQ_FIN: begin
        out_kept_total_nxt = run_r;
      end
      REQ_REMAP: begin
        out_new_a_nxt       = res_a_r;
        out_new_b_nxt       = res_b_r;
        out_new_c_nxt       = res_c_r;
        out_range_error_nxt = tri_err;
      end
      REQ_QUERY: begin
        out_vertex_kept_nxt      = res_kept_r;
        out_vertex_new_index_nxt = res_new_r;
        out_range_error_nxt      = !q_ok;
      end
      default: begin
        out_range_error_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r   <= '0;
      idx_r  <= '0;
      run_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        vc_r <= cfg_vertex_count;
      end
      idx_r  <= idx_nxt;
      run_r  <= run_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r <= in_req_type;
      ca_r  <= in_corner_a;
      cb_r  <= in_corner_b;
      cc_r  <= in_corner_c;
      q_r   <= in_query_vertex;
    end
    if (cmd.fin_step) begin
      pidx_r <= idx_r[IDX_W-1:0];
    end
    if (cmd.rank_cap) begin
      unique case (cmd.cap_slot)
        2'd0:    res_a_r <= cap_val;
        2'd1:    res_b_r <= cap_val;
        default: res_c_r <= cap_val;
      endcase
    end
    if (cmd.q_cap) begin
      res_kept_r <= kept_now;
      res_new_r  <= kept_now ? rk_rdata : '0;
    end
    if (cmd.load_out) begin
      out_new_a            <= out_new_a_nxt;
      out_new_b            <= out_new_b_nxt;
      out_new_c            <= out_new_c_nxt;
      out_vertex_kept      <= out_vertex_kept_nxt;
      out_vertex_new_index <= out_vertex_new_index_nxt;
      out_kept_total       <= out_kept_total_nxt;
      out_range_error      <= out_range_error_nxt;
    end
  end

endmodule

[rtl/core/uvc_ctrl.sv]
// uvc_ctrl: request sequencer for clear, mark, finalize, remap and query
// depends on uvc_pkg
module uvc_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [uvc_pkg::REQ_W-1:0] in_req_type,
  output logic                      out_valid,
  input  logic                      out_ready,
  output uvc_pkg::cmd_t             cmd,
  input  uvc_pkg::status_t          status
);
  import uvc_pkg::*;

  typedef enum logic [7:0] {
    ST_INIT  = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_CLR   = 8'b0000_0100,
    ST_MARK  = 8'b0000_1000,
    ST_FIN   = 8'b0001_0000,
    ST_REMAP = 8'b0010_0000,
    ST_QUERY = 8'b0100_0000,
    ST_RES   = 8'b1000_0000
  } state_t;

  localparam logic [SEL_W-1:0] LAST_CORNER = SEL_W'(TRI_CORNERS - 1);
  localparam logic [SEL_W-1:0] LAST_CAP    = SEL_W'(TRI_CORNERS);

  state_t           state_r, state_nxt;
  logic [SEL_W-1:0] step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_INIT, ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (status.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        step_nxt = '0;
        if (in_fire) begin
          cmd.latch_in = 1'b1;
          unique case (in_req_type)
            REQ_CLEAR: state_nxt = ST_CLR;
            REQ_MARK:  state_nxt = ST_MARK;
            REQ_FIN:   state_nxt = ST_FIN;
            REQ_REMAP: state_nxt = ST_REMAP;
            REQ_QUERY: state_nxt = ST_QUERY;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MARK: begin
        cmd.mark_step = 1'b1;
        cmd.sel       = step_r;
        step_nxt      = step_r + SEL_W'(1);
        if (step_r == LAST_CORNER) begin
          state_nxt = ST_RES;
        end
      end
      ST_REMAP: begin
        // read one corner a cycle, capture the one read the cycle before
        cmd.sel      = step_r;
        cmd.rank_cap = (step_r != '0);
        cmd.cap_slot = step_r - SEL_W'(1);
        step_nxt     = step_r + SEL_W'(1);
        if (step_r == LAST_CAP) begin
          state_nxt = ST_RES;
        end
      end
      ST_QUERY: begin
        cmd.use_q = 1'b1;
        cmd.q_cap = (step_r != '0);
        step_nxt  = step_r + SEL_W'(1);
        if (step_r != '0) begin
          state_nxt = ST_RES;
        end
      end
      ST_FIN: begin
        cmd.fin_step = 1'b1;
        if (status.fin_done) begin
          state_nxt = ST_RES;
        end
      end
      ST_RES: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/unused_vertex_compaction.sv]
// unused_vertex_compaction: top level joining sequencer and datapath
// depends on uvc_pkg, uvc_ifs, uvc_ctrl and uvc_dp
//
// Mesh cleanup engine: a one-bit used flag per vertex (up to 4096) and a rank
// table. Mark sets the flags of a triangle's corners, finalize gives each
// vertex below min(vertex_count, 4096) the count of used vertices below it and
// reports the kept total, remap turns three corners into ranks, query reports
// one vertex's kept flag and rank, and clear wipes the flags. Indexes at or
// above the count raise range_error and are not written. One request is in
// work at a time: mark sets its corners in turn, remap reads them in turn,
// finalize does one bitmap read and one rank write per vertex, and clear
// zeroes one bitmap entry per cycle and loads no result. After reset a
// clearing pass over all 4096 entries runs before the first request is
// taken; config writes are taken at any time but belong between requests.
// The result sits in an output register, so a new request is taken while
// the last result waits to be transferred.
module unused_vertex_compaction (
  input  logic      clk,
  input  logic      rst_n,
  uvc_in_if.sink    in_ch,
  uvc_out_if.source out_ch,
  uvc_cfg_if.sink   cfg_ch
);
  import uvc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // config register always writable
  assign cfg_ch.ready = 1'b1;

  uvc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_req_type (in_ch.req_type),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .cmd         (cmd),
    .status      (status)
  );

  uvc_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_req_type          (in_ch.req_type),
    .in_corner_a          (in_ch.corner_a),
    .in_corner_b          (in_ch.corner_b),
    .in_corner_c          (in_ch.corner_c),
    .in_query_vertex      (in_ch.query_vertex),
    .cfg_we               (cfg_ch.valid),
    .cfg_vertex_count     (cfg_ch.vertex_count),
    .out_new_a            (out_ch.new_a),
    .out_new_b            (out_ch.new_b),
    .out_new_c            (out_ch.new_c),
    .out_vertex_kept      (out_ch.vertex_kept),
    .out_vertex_new_index (out_ch.vertex_new_index),
    .out_kept_total       (out_ch.kept_total),
    .out_range_error      (out_ch.range_error)
  );

  // a clear transfer starts the sweep, requests are held off
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.req_type == REQ_CLEAR) |=> !in_ch.ready)
    else $error("clear did not start the sweep");

  // an unknown request code is dropped and the block stays ready
  a_unknown_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.req_type != REQ_CLEAR &&
     in_ch.req_type != REQ_MARK && in_ch.req_type != REQ_FIN &&
     in_ch.req_type != REQ_REMAP && in_ch.req_type != REQ_QUERY) |=> in_ch.ready)
    else $error("unknown request was not dropped");

  // result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("output register overwritten");

  // a mark walks its three corners and loads its result before input reopens
  a_mark_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.req_type == REQ_MARK) |=> !in_ch.ready [*4])
    else $error("mark finished early");

endmodule
